>>> hw/rtl/sws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_SA   = 4'd1,
        PH_SB   = 4'd2,
        PH_SC   = 4'd3,
        PH_BA   = 4'd4,
        PH_BB   = 4'd5,
        PH_BC   = 4'd6,
        PH_AA   = 4'd7,
        PH_AB   = 4'd8,
        PH_TA   = 4'd9,
        PH_TB   = 4'd10,
        PH_TC   = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        CFG_HALF_PERIOD  = 2'd0,
        CFG_EDGE_DELAY   = 2'd1,
        CFG_DISP_CONTROL = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic clk;
        logic dio;
        logic drive;
    } t_pins;

    typedef struct packed {
        logic [15:0] half_ticks;
        logic [15:0] delay_ticks;
        logic [7:0]  control;
    } t_timing;

    localparam logic [7:0]  BYTE_DATA_CMD  = 8'h40;
    localparam logic [7:0]  BYTE_ADDR_CMD  = 8'hC0;
    localparam logic [7:0]  CONTROL_RESET  = 8'h8A;
    localparam logic [15:0] HALF_RESET     = 16'd5;
    localparam logic [15:0] HALF_MIN       = 16'd2;
    localparam logic [7:0]  DELAY_RESET    = 8'd1;
    localparam logic [1:0]  FRAME_LAST     = 2'd2;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;
    localparam int          INPUT_DIGITS   = 4;
    localparam t_pins       PINS_RESET     = '{clk: 1'b1, dio: 1'b1, drive: 1'b1};

endpackage

`default_nettype wire

>>> hw/rtl/sws_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sws_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] digit_0;
    logic [7:0] digit_1;
    logic [7:0] digit_2;
    logic [7:0] digit_3;

    modport source (output valid, action, digit_0, digit_1, digit_2, digit_3,
                    input ready);
    modport sink (input valid, action, digit_0, digit_1, digit_2, digit_3,
                  output ready);
endinterface

interface sws_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic rejected;

    modport source (output valid, clk_level, dio_level, dio_drive, busy_res, rejected,
                    input ready);
    modport sink (input valid, clk_level, dio_level, dio_drive, busy_res, rejected,
                  output ready);
endinterface

interface sws_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sws_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module sws_cfg
    import sws_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sws_cfg_if.sink      i_cfg,
    output t_timing      o_timing
);

    logic [15:0] r_half;
    logic [7:0]  r_delay;
    logic [7:0]  r_control;
    logic [15:0] half_eff;
    logic [15:0] delay_lo;
    logic [15:0] delay_hi;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= HALF_RESET;
            r_delay   <= DELAY_RESET;
            r_control <= CONTROL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_PERIOD:  r_half    <= i_cfg.data;
                CFG_EDGE_DELAY:   r_delay   <= i_cfg.data[7:0];
                CFG_DISP_CONTROL: r_control <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // clamp half period to two, delay to one .. half - 1
    always_comb begin
        half_eff = (r_half < HALF_MIN) ? HALF_MIN : r_half;
        delay_hi = half_eff - 16'd1;
        delay_lo = (r_delay == 8'd0) ? 16'd1 : {8'd0, r_delay};
        o_timing.half_ticks  = half_eff;
        o_timing.delay_ticks = (delay_lo > delay_hi) ? delay_hi : delay_lo;
        o_timing.control     = r_control;
    end

endmodule

`default_nettype wire

>>> hw/rtl/sws_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module sws_seq
    import sws_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_timing  i_timing,
    sws_in_if.sink        i_in,
    sws_out_if.source     o_out
);

    localparam logic [3:0] ADDR_FRAME_BYTES = 4'(DIGIT_COUNT + 1);

    logic [7:0] r_digits [DIGIT_COUNT];
    logic [7:0] in_digits [INPUT_DIGITS];

    t_phase      r_phase, n_phase;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_bit, n_bit;
    logic [2:0]  r_byte, n_byte;
    logic [1:0]  r_frame, n_frame;
    logic [15:0] r_timer, n_timer;
    t_pins       r_pins, n_pins;

    logic        r_out_valid;
    t_pins       r_res_pins;
    logic        r_res_busy;
    logic        r_res_rej;

    logic        accept;
    logic        latch;
    logic        rej;
    logic        go;
    t_phase      tgt;
    logic [15:0] t_dec;
    logic [7:0]  next_byte;
    logic [2:0]  sel_byte;
    logic [3:0]  frame_bytes;
    logic [15:0] wait_rest;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    assign in_digits[0] = i_in.digit_0;
    assign in_digits[1] = i_in.digit_1;
    assign in_digits[2] = i_in.digit_2;
    assign in_digits[3] = i_in.digit_3;

    // byte selected for the frame and byte index that the step leads to
    always_comb begin
        next_byte = 8'd0;
        sel_byte  = (r_phase == PH_AB) ? r_byte + 3'd1 : r_byte;
        if (r_frame == 2'd0) begin
            next_byte = BYTE_DATA_CMD;
        end else if (r_frame == 2'd1) begin
            if (sel_byte == 3'd0) begin
                next_byte = BYTE_ADDR_CMD;
            end else begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    if (4'(DIGIT_COUNT - i) == {1'b0, sel_byte}) begin
                        next_byte = r_digits[i];
                    end
                end
            end
        end else begin
            next_byte = i_timing.control;
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_frame     = r_frame;
        n_timer     = r_timer;
        n_pins      = r_pins;
        latch       = 1'b0;
        rej         = 1'b0;
        go          = 1'b0;
        tgt         = PH_IDLE;
        t_dec       = (r_timer != 16'd0) ? r_timer - 16'd1 : 16'd0;
        frame_bytes = (r_frame == 2'd1) ? ADDR_FRAME_BYTES : 4'd1;
        wait_rest   = i_timing.half_ticks - i_timing.delay_ticks;

        if (accept) begin
            if (i_in.action) begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    latch   = 1'b1;
                    n_frame = 2'd0;
                    n_byte  = 3'd0;
                    n_bit   = 4'd0;
                    go      = 1'b1;
                    tgt     = PH_SA;
                end
            end else if (r_phase != PH_IDLE) begin
                n_timer = t_dec;
                if (t_dec == 16'd0) begin
                    case (r_phase)
                        PH_SA: begin go = 1'b1; tgt = PH_SB; end
                        PH_SB: begin go = 1'b1; tgt = PH_SC; end
                        PH_SC: begin
                            n_bit = 4'd0;
                            go    = 1'b1;
                            tgt   = PH_BA;
                        end
                        PH_BA: begin go = 1'b1; tgt = PH_BB; end
                        PH_BB: begin go = 1'b1; tgt = PH_BC; end
                        PH_BC: begin
                            n_shift = {1'b0, r_shift[7:1]};
                            n_bit   = r_bit + 4'd1;
                            go      = 1'b1;
                            tgt     = (n_bit >= BITS_PER_BYTE) ? PH_AA : PH_BA;
                        end
                        PH_AA: begin go = 1'b1; tgt = PH_AB; end
                        PH_AB: begin
                            n_pins.clk   = 1'b0;
                            n_pins.drive = 1'b1;
                            n_byte       = r_byte + 3'd1;
                            go           = 1'b1;
                            if ({1'b0, n_byte} < frame_bytes) begin
                                n_bit = 4'd0;
                                tgt   = PH_BA;
                            end else begin
                                tgt   = PH_TA;
                            end
                        end
                        PH_TA: begin go = 1'b1; tgt = PH_TB; end
                        PH_TB: begin go = 1'b1; tgt = PH_TC; end
                        PH_TC: begin
                            n_pins.dio = 1'b1;
                            n_byte     = 3'd0;
                            if (r_frame != FRAME_LAST) begin
                                n_frame = r_frame + 2'd1;
                                go      = 1'b1;
                                tgt     = PH_SA;
                            end else begin
                                n_frame = 2'd0;
                                n_bit   = 4'd0;
                                n_phase = PH_IDLE;
                                n_timer = 16'd0;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_timer = 16'd0;
                        end
                    endcase
                end
            end
        end

        // load a new byte when a bit run starts from the start or ack step
        if (go && tgt == PH_BA && (r_phase == PH_SC || r_phase == PH_AB)) begin
            n_shift = next_byte;
        end

        if (go) begin
            n_phase = tgt;
            case (tgt)
                PH_SA: begin n_pins.clk = 1'b1; n_timer = i_timing.delay_ticks; end
                PH_SB: begin n_pins.dio = 1'b1; n_timer = wait_rest; end
                PH_SC: begin n_pins.dio = 1'b0; n_timer = i_timing.half_ticks; end
                PH_BA: begin n_pins.clk = 1'b0; n_timer = i_timing.delay_ticks; end
                PH_BB: begin n_pins.dio = n_shift[0]; n_timer = wait_rest; end
                PH_BC: begin n_pins.clk = 1'b1; n_timer = i_timing.half_ticks; end
                PH_AA: begin
                    n_pins.clk   = 1'b0;
                    n_pins.drive = 1'b0;
                    n_timer      = i_timing.half_ticks;
                end
                PH_AB: begin n_pins.clk = 1'b1; n_timer = i_timing.half_ticks; end
                PH_TA: begin n_pins.clk = 1'b0; n_timer = i_timing.delay_ticks; end
                PH_TB: begin n_pins.dio = 1'b0; n_timer = wait_rest; end
                PH_TC: begin n_pins.clk = 1'b1; n_timer = i_timing.half_ticks; end
                default: begin n_phase = PH_IDLE; n_timer = 16'd0; end
            endcase
        end
    end

    // result payload
    always_comb begin
        o_out.valid     = r_out_valid;
        o_out.clk_level = r_res_pins.clk;
        o_out.dio_level = r_res_pins.dio;
        o_out.dio_drive = r_res_pins.drive;
        o_out.busy_res  = r_res_busy;
        o_out.rejected  = r_res_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= 8'd0;
            r_bit       <= 4'd0;
            r_byte      <= 3'd0;
            r_frame     <= 2'd0;
            r_timer     <= 16'd0;
            r_pins      <= PINS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_frame <= n_frame;
            r_timer <= n_timer;
            r_pins  <= n_pins;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_pins <= n_pins;
            r_res_busy <= (n_phase != PH_IDLE);
            r_res_rej  <= rej;
        end
        if (latch) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (i < INPUT_DIGITS) begin
                    r_digits[i] <= in_digits[i[1:0]];
                end else begin
                    r_digits[i] <= 8'd0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/seg_display_two_wire_writer.sv
// two-wire seven-segment display writer
//
// i_in: one transaction per time tick (action 0) or refresh request (action 1)
// carrying four digit segment codes. o_out: one transaction per input
// transaction with the pin levels after that update, busy and rejected.
// i_cfg: register writes (0 half period ticks, 1 edge delay ticks,
// 2 display control byte), always ready, to be made while the block is idle.
// An accepted request while idle latches the digits and starts the three
// frames; a request while busy is dropped and flagged as rejected.
// The result of a transaction is held in the output register from the next
// clock edge. Throughput is one transaction per cycle while the receiver takes
// results, set by the single state update between input and result register.
// When the receiver stalls, the output register holds its result and i_in
// ready drops until it is taken; no transaction is lost.
// Reset (synchronous, active low) leaves the block idle with clock high, data
// high and driven, half period 5, edge delay 1, control byte 0x8A.
`timescale 1ns / 1ps
`default_nettype none

module seg_display_two_wire_writer
    import sws_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sws_cfg_if.sink    i_cfg,
    sws_in_if.sink     i_in,
    sws_out_if.source  o_out
);

    t_timing timing;

    sws_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_timing (timing)
    );

    sws_seq #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_timing (timing),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
